@@ sv/hsed_pkg.sv @@
// Package for the Hamming single-error decoder: field widths and
// constant helper functions for position masks and bit ranks.
// No dependencies.
`timescale 1ns / 1ps

package hsed_pkg;

  localparam int CW_W   = 63;
  localparam int LEN_W  = 6;
  localparam int DATA_W = 57;
  localparam int SYN_W  = 6;

  // Syndrome bit k covers every position whose binary index has bit k set.
  function automatic logic [CW_W-1:0] pos_bit_mask(input int k);
    logic [CW_W-1:0] m;
    m = '0;
    for (int i = 0; i < CW_W; i++) begin
      m[i] = 1'(((i + 1) >> k) & 1);
    end
    return m;
  endfunction

  function automatic bit is_check_pos(input int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // floor(log2 p) for an elaboration-time position
  function automatic int flog2(input int p);
    int r;
    r = 0;
    for (int i = 0; i < 7; i++) begin
      if ((p >> i) > 1) r = i + 1;
    end
    return r;
  endfunction

  // Packed data index of a non-check position: positions below it minus
  // check positions below it.
  function automatic int data_index(input int p);
    return p - 2 - flog2(p);
  endfunction

  // Index of the highest set bit of a length; 0 for a zero input.
  function automatic logic [2:0] msb_index(input logic [LEN_W-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Syndrome stage to correction stage
  typedef struct packed {
    logic [SYN_W-1:0] syndrome;
    logic [LEN_W-1:0] length;
  } syn_info_t;

endpackage

@@ sv/hsed_in_if.sv @@
// Request channel of the Hamming decoder: codeword and length.
// Depends on hsed_pkg.
`timescale 1ns / 1ps

interface hsed_in_if import hsed_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CW_W-1:0]  codeword;
  logic [LEN_W-1:0] code_length;

  modport source (output valid, output codeword, output code_length, input ready);
  modport sink   (input valid, input codeword, input code_length, output ready);
endinterface

@@ sv/hsed_out_if.sv @@
// Result channel of the Hamming decoder: data, length, syndrome, flags.
// Depends on hsed_pkg.
`timescale 1ns / 1ps

interface hsed_out_if import hsed_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_bits;
  logic [LEN_W-1:0]  data_length;
  logic [SYN_W-1:0]  syndrome;
  logic              corrected;
  logic              syndrome_out_of_range;

  modport source (output valid, output data_bits, output data_length,
                  output syndrome, output corrected, output syndrome_out_of_range,
                  input ready);
  modport sink   (input valid, input data_bits, input data_length,
                  input syndrome, input corrected, input syndrome_out_of_range,
                  output ready);
endinterface

@@ sv/hamming_single_error_decoder.sv @@
// Top level of the variable-length Hamming single-error decoder.
// Depends on hsed_pkg, hsed_in_if, hsed_out_if, hsed_syndrome, hsed_extract.
`timescale 1ns / 1ps

//  channel  dir  payload
//  din      in   codeword[62:0], code_length[5:0]
//  dout     out  data_bits[56:0], data_length, syndrome, corrected,
//                syndrome_out_of_range
//
// Two register stages: the request is captured in an input register, the
// syndrome/correct/pack logic sits between it and the result register.
// One request per cycle while dout is not stalled.
// rst (sync) empties both stages; payload registers are not reset.
// A stalled result holds; the input stage still fills behind it, so
// din.ready drops only when both stages are full and dout is stalled.

module hamming_single_error_decoder import hsed_pkg::*; #(
  parameter int MAX_CODE_LENGTH = 63
) (
  input logic        clk,
  input logic        rst,
  hsed_in_if.sink    din,
  hsed_out_if.source dout
);

  // input stage
  logic             s1_valid;
  logic [CW_W-1:0]  s1_codeword;
  logic [LEN_W-1:0] s1_length;

  // result stage
  logic              res_valid;
  logic [DATA_W-1:0] res_data;
  logic [LEN_W-1:0]  res_dlen;
  logic [SYN_W-1:0]  res_syn;
  logic              res_fix;
  logic              res_oor;

  logic              res_load;
  logic              s1_load;

  logic [CW_W-1:0]   masked;
  syn_info_t         info;
  logic [DATA_W-1:0] data_next;
  logic [LEN_W-1:0]  dlen_next;
  logic              fix_next;
  logic              oor_next;

  // result register frees up when empty or being taken
  assign res_load = !res_valid || dout.ready;
  assign s1_load  = !s1_valid || res_load;
  assign din.ready = s1_load;

  hsed_syndrome #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) u_syndrome (
    .codeword   (s1_codeword),
    .code_length(s1_length),
    .masked     (masked),
    .info       (info)
  );

  hsed_extract u_extract (
    .masked               (masked),
    .info                 (info),
    .data_bits            (data_next),
    .data_length          (dlen_next),
    .corrected            (fix_next),
    .syndrome_out_of_range(oor_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) res_valid <= s1_valid;
      if (s1_load)  s1_valid  <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && din.valid) begin
      s1_codeword <= din.codeword;
      s1_length   <= din.code_length;
    end
    if (res_load && s1_valid) begin
      res_data <= data_next;
      res_dlen <= dlen_next;
      res_syn  <= info.syndrome;
      res_fix  <= fix_next;
      res_oor  <= oor_next;
    end
  end

  assign dout.valid                 = res_valid;
  assign dout.data_bits             = res_data;
  assign dout.data_length           = res_dlen;
  assign dout.syndrome              = res_syn;
  assign dout.corrected             = res_fix;
  assign dout.syndrome_out_of_range = res_oor;

endmodule

@@ sv/hsed_syndrome.sv @@
// Length clamp, bit masking and even-parity syndrome XOR trees.
// Depends on hsed_pkg.
`timescale 1ns / 1ps

module hsed_syndrome import hsed_pkg::*; #(
  parameter int MAX_CODE_LENGTH = 63
) (
  input  logic [CW_W-1:0]  codeword,
  input  logic [LEN_W-1:0] code_length,
  output logic [CW_W-1:0]  masked,
  output syn_info_t        info
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_CODE_LENGTH);

  logic [LEN_W-1:0] len;

  assign len = (code_length > MaxLen) ? MaxLen : code_length;

  // keep positions 1..len, i.e. bit indexes below len
  always_comb begin
    for (int i = 0; i < CW_W; i++) begin
      masked[i] = codeword[i] & (LEN_W'(i) < len);
    end
  end

  always_comb begin
    for (int k = 0; k < SYN_W; k++) begin
      info.syndrome[k] = ^(masked & pos_bit_mask(k));
    end
    info.length = len;
  end

endmodule

@@ sv/hsed_extract.sv @@
// Single-bit correction, out-of-range flag and check-bit removal.
// Depends on hsed_pkg.
`timescale 1ns / 1ps

module hsed_extract import hsed_pkg::*; (
  input  logic [CW_W-1:0]   masked,
  input  syn_info_t         info,
  output logic [DATA_W-1:0] data_bits,
  output logic [LEN_W-1:0]  data_length,
  output logic              corrected,
  output logic              syndrome_out_of_range
);

  logic             syn_nz;
  logic [CW_W-1:0]  fixed;
  logic [LEN_W-1:0] check_count;

  assign syn_nz                = info.syndrome != '0;
  assign corrected             = syn_nz && (info.syndrome <= info.length);
  assign syndrome_out_of_range = syn_nz && (info.syndrome > info.length);

  always_comb begin
    for (int i = 0; i < CW_W; i++) begin
      fixed[i] = masked[i] ^ (corrected && (info.syndrome == LEN_W'(i + 1)));
    end
  end

  // Data positions map to fixed packed slots; masking already zeroed
  // everything past the length.
  for (genvar p = 1; p <= CW_W; p++) begin : g_pack
    if (!is_check_pos(p)) begin : g_data
      assign data_bits[data_index(p)] = fixed[p-1];
    end
  end

  // check positions not above len: floor(log2 len) + 1
  assign check_count = LEN_W'(msb_index(info.length)) + LEN_W'(1);
  assign data_length = (info.length == '0) ? '0 : info.length - check_count;

endmodule

@@ test/hamming_single_error_decoder_tb.sv @@
// Self-checking bench for the variable-length Hamming single-error decoder.
// Depends on hsed_pkg, hsed_in_if, hsed_out_if and hamming_single_error_decoder.
`timescale 1ns / 1ps

module hamming_single_error_decoder_tb;
  import hsed_pkg::*;

  localparam int MAX_CODE_LENGTH = 63;
  localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES    = 10;    // block has an input and a result register

  // One decoded result as the block should present it.
  typedef struct packed {
    logic [DATA_W-1:0] data_bits;
    logic [LEN_W-1:0]  data_length;
    logic [SYN_W-1:0]  syndrome;
    logic              corrected;
    logic              out_of_range;
  } decoded_t;

  logic clk;
  logic rst;

  hsed_in_if  din_ch ();
  hsed_out_if dout_ch ();

  hamming_single_error_decoder #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_ch.sink),
    .dout (dout_ch.source)
  );

  decoded_t pending_results[$];  // decoded results still owed by the block, oldest first
  int       mismatches;
  int       quiet_cycles;
  bit       no_idle;             // both sides run flat out while set

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder predictor
  // ---------------------------------------------------------------------------

  // Even-parity syndrome: XOR of the positions of the set bits inside the length.
  function automatic logic [SYN_W-1:0] parity_syndrome(input logic [CW_W-1:0] cw,
                                                       input int len);
    logic [SYN_W-1:0] syn;
    syn = '0;
    for (int pos = 1; pos <= len; pos++) begin
      if (cw[pos-1]) syn ^= SYN_W'(pos);
    end
    return syn;
  endfunction

  function automatic decoded_t decode_codeword(input logic [CW_W-1:0] cw_in,
                                               input logic [LEN_W-1:0] code_len);
    decoded_t        res;
    logic [CW_W-1:0] cw;
    int              len;
    int              dlen;
    cw  = cw_in;
    len = int'(code_len);
    if (len > MAX_CODE_LENGTH) len = MAX_CODE_LENGTH;
    res = '0;
    res.syndrome = parity_syndrome(cw, len);
    if (res.syndrome != '0) begin
      if (int'(res.syndrome) <= len) begin
        cw[res.syndrome-1] = ~cw[res.syndrome-1];
        res.corrected = 1'b1;
      end else begin
        // Syndrome points past the codeword: report it, leave the bits alone.
        res.out_of_range = 1'b1;
      end
    end
    dlen = 0;
    for (int pos = 1; pos <= len; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (dlen < DATA_W) res.data_bits[dlen] = cw[pos-1];
        dlen++;
      end
    end
    res.data_length = LEN_W'(dlen);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Turns arbitrary bits into a clean codeword of the given length; bits above
  // the length are kept as they are, the block must ignore them.
  function automatic logic [CW_W-1:0] make_codeword(input logic [CW_W-1:0] raw,
                                                    input int len);
    logic [CW_W-1:0]  cw;
    logic [SYN_W-1:0] syn;
    cw = raw;
    for (int k = 0; k < SYN_W; k++) begin
      if ((1 << k) <= len) cw[(1 << k) - 1] = 1'b0;
    end
    syn = parity_syndrome(cw, len);
    for (int k = 0; k < SYN_W; k++) begin
      if (syn[k]) cw[(1 << k) - 1] = 1'b1;
    end
    return cw;
  endfunction

  function automatic logic [CW_W-1:0] bit_at(input int pos);
    return CW_W'(1) << (pos - 1);
  endfunction

  function automatic logic [CW_W-1:0] random_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       r = r & {$urandom, $urandom};  // sparse
      1:       r = r | {$urandom, $urandom};  // dense
      default: ;
    endcase
    return r[CW_W-1:0];
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return $urandom_range(0, 3);
    if (r < 28) return MAX_CODE_LENGTH;
    return $urandom_range(0, MAX_CODE_LENGTH);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Presents one request and returns at the edge that accepts it. valid is
  // left high, so back-to-back requests never drop it within one step.
  task automatic send_request(input logic [CW_W-1:0] cw, input int len);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid       <= 1'b1;
    din_ch.codeword    <= cw;
    din_ch.code_length <= LEN_W'(len);
    do @(posedge clk); while (!din_ch.ready);
    pending_results.push_back(decode_codeword(cw, LEN_W'(len)));
  endtask

  // Random request: clean codeword, single error, double error or plain noise.
  task automatic send_random_request(input int len);
    logic [CW_W-1:0] cw;
    int              kind;
    int              p1;
    int              p2;
    kind = $urandom_range(0, 99);
    cw   = random_bits();
    if (kind < 85) cw = make_codeword(cw, len);
    if (len >= 1 && kind >= 35 && kind < 85) begin
      p1 = $urandom_range(1, len);
      cw ^= bit_at(p1);
      // Two flips can push the syndrome past the length.
      if (kind >= 70 && len >= 2) begin
        do p2 = $urandom_range(1, len); while (p2 == p1);
        cw ^= bit_at(p2);
      end
    end
    send_request(cw, len);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checker, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    int stall_left;
    stall_left = 0;
    dout_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (no_idle) begin
        dout_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        dout_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 70) begin
        dout_ch.ready <= 1'b1;
      end else begin
        dout_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40) $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && dout_ch.valid && dout_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(dout_ch.data_bits), '0);
      end else begin
        want = pending_results.pop_front();
        if (dout_ch.data_bits !== want.data_bits)
          report_mismatch("data_bits", 64'(dout_ch.data_bits), 64'(want.data_bits));
        if (dout_ch.data_length !== want.data_length)
          report_mismatch("data_length", 64'(dout_ch.data_length), 64'(want.data_length));
        if (dout_ch.syndrome !== want.syndrome)
          report_mismatch("syndrome", 64'(dout_ch.syndrome), 64'(want.syndrome));
        if (dout_ch.corrected !== want.corrected)
          report_mismatch("corrected", 64'(dout_ch.corrected), 64'(want.corrected));
        if (dout_ch.syndrome_out_of_range !== want.out_of_range)
          report_mismatch("syndrome_out_of_range", 64'(dout_ch.syndrome_out_of_range),
                          64'(want.out_of_range));
      end
    end
  end

  // Any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL hamming_single_error_decoder");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and the corner cases of the decode.
  task automatic test_directed_cases();
    logic [CW_W-1:0] ones;
    ones = '1;
    send_request(ones, 0);                              // zero length, nothing valid
    send_request('0, 1);
    send_request(bit_at(1), 1);                         // only a check bit, flipped back
    send_request(CW_W'(7), 3);                          // clean, one data bit
    send_request(CW_W'(3), 3);                          // error on the data bit
    send_request(bit_at(2) | bit_at(4), 5);             // syndrome 6 past length 5
    send_request(bit_at(3) | bit_at(4), 6);             // syndrome 7 past length 6
    send_request(bit_at(1) | bit_at(4), 4);             // syndrome 5 past length 4
    send_request(CW_W'(3), 2);                          // syndrome 3 past length 2
    send_request(bit_at(1) | bit_at(62), 62);           // syndrome 63 past length 62
    send_request('0, MAX_CODE_LENGTH);
    send_request(ones, MAX_CODE_LENGTH);                // clean, all 57 data bits set
    send_request(make_codeword(ones, MAX_CODE_LENGTH) ^ bit_at(63), MAX_CODE_LENGTH);
    send_request(make_codeword(random_bits(), MAX_CODE_LENGTH) ^ bit_at(1),
                 MAX_CODE_LENGTH);
    send_request(make_codeword(random_bits(), MAX_CODE_LENGTH) ^ bit_at(32),
                 MAX_CODE_LENGTH);
    send_request(make_codeword(ones, 7), 7);            // bits above length all set
    send_request(make_codeword('0, 7) | ~CW_W'(127), 7);
    send_request(bit_at(5) | bit_at(9), MAX_CODE_LENGTH);  // double error, miscorrects
    send_request(make_codeword(ones, 32) ^ bit_at(32), 32);
    send_request(make_codeword(random_bits(), 33) ^ bit_at(33), 33);
  endtask

  // Full rate on both sides: a request every cycle, no stalls.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (150) send_random_request(pick_length());
    no_idle = 1'b0;
  endtask

  // Short codes, where the check bits dominate and out-of-range is common.
  task automatic test_short_codes();
    repeat (100) send_random_request($urandom_range(0, 7));
  endtask

  // Bulk of the run: mixed lengths and error patterns under random idling.
  task automatic test_random_codewords();
    for (int i = 0; i < 1550; i++) begin
      // Occasional full-rate stretch in the middle of the random traffic.
      no_idle = (i % 400) >= 360;
      send_random_request(pick_length());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    no_idle    = 1'b0;
    rst                <= 1'b1;
    din_ch.valid       <= 1'b0;
    din_ch.codeword    <= '0;
    din_ch.code_length <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_back_to_back();
    test_short_codes();
    test_random_codewords();

    din_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS hamming_single_error_decoder");
    end else begin
      $display("FAIL hamming_single_error_decoder");
    end
    $finish;
  end

endmodule
